@@ hdl/ctr_pkg.sv @@
package ctr_pkg;

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // result events
    localparam logic [1:0] EV_SEND = 2'd0;
    localparam logic [1:0] EV_DATA = 2'd1;
    localparam logic [1:0] EV_DONE = 2'd2;
    localparam logic [1:0] EV_FAIL = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
    localparam logic [2:0] ERR_SIGNAL   = 3'd2;
    localparam logic [2:0] ERR_LONG     = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // protocol phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SYN     = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_HANGUP  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_SYN_CODE      = 3'd0;
    localparam logic [2:0] REG_ACK_CODE      = 3'd1;
    localparam logic [2:0] REG_HANGUP_CODE   = 3'd2;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;
    localparam logic [2:0] REG_MAX_PAYLOAD   = 3'd5;
    localparam logic [2:0] REG_CAPACITY      = 3'd6;

    localparam logic [1:0] HDR_LAST = 2'd3;

    typedef struct packed {
        logic [7:0]  syn_code;
        logic [7:0]  ack_code;
        logic [7:0]  hangup_code;
        logic [7:0]  retry_limit;
        logic [15:0] timeout_ticks;
        logic [15:0] max_payload;
        logic [15:0] capacity;
    } t_cfg;

    // one queue entry: a result, optionally followed by an ACK request
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  value;
        logic [15:0] offset;
        logic [15:0] total_len;
        logic [2:0]  error_code;
        logic        ack_after;
    } t_entry;

endpackage

@@ hdl/chunked_transfer_receiver.sv @@
// Channel   Dir  Handshake             tdata                         tuser
// s (in)    in   i_s_tvalid/o_s_tready rx_byte[7:0]                  kind[1:0]
// m (out)   out  o_m_tvalid/i_m_tready value, offset, total_len, err event_res[1:0]
// cfg       in   i_cfg_we              i_cfg_addr index, i_cfg_wdata value
//
// One input item a cycle while the queue has room; its results come out one a cycle while
// i_m_tready allows, through a QUEUE_DEPTH-entry queue and then an output register.
// A payload byte that closes a frame yields two results: its data, then an ACK request.
// Reset is synchronous, active low, and clears control state and config to defaults.
// o_s_tready drops only when the queue is full; the output side stalls on its own.
module chunked_transfer_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [7:0] value, [23:8] offset, [39:24] total_len,
                                     // [42:40] error_code, [47:43] zero
    output logic [1:0]  o_m_tuser,   // [1:0] event_res
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    ctr_pkg::t_cfg   r_cfg;
    ctr_pkg::t_entry front_entry, head;
    logic            push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.syn_code      <= 8'd22;
            r_cfg.ack_code      <= 8'd6;
            r_cfg.hangup_code   <= 8'd4;
            r_cfg.retry_limit   <= 8'd3;
            r_cfg.timeout_ticks <= 16'd1000;
            r_cfg.max_payload   <= 16'd256;
            r_cfg.capacity      <= 16'd65535;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ctr_pkg::REG_SYN_CODE:      r_cfg.syn_code      <= i_cfg_wdata[7:0];
                ctr_pkg::REG_ACK_CODE:      r_cfg.ack_code      <= i_cfg_wdata[7:0];
                ctr_pkg::REG_HANGUP_CODE:   r_cfg.hangup_code   <= i_cfg_wdata[7:0];
                ctr_pkg::REG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_cfg_wdata[7:0];
                ctr_pkg::REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_wdata;
                ctr_pkg::REG_MAX_PAYLOAD:   r_cfg.max_payload   <= i_cfg_wdata;
                ctr_pkg::REG_CAPACITY:      r_cfg.capacity      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = !full;

    ctr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_ready   (o_s_tready),
        .i_kind    (i_s_tuser),
        .i_rx_byte (i_s_tdata),
        .i_cfg     (r_cfg),
        .o_push    (push),
        .o_entry   (front_entry)
    );

    ctr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    ctr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (empty),
        .i_ack_code (r_cfg.ack_code),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ hdl/ctr_front.sv @@
module ctr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_ready,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_rx_byte,
    input  ctr_pkg::t_cfg        i_cfg,
    output logic                 o_push,
    output ctr_pkg::t_entry      o_entry
);

    logic [2:0]  r_phase,  n_phase;
    logic [8:0]  r_mis,    n_mis;
    logic [1:0]  r_hidx,   n_hidx;
    logic [15:0] r_frames, n_frames;
    logic [15:0] r_left,   n_left;
    logic [15:0] r_total,  n_total;
    logic [15:0] r_idle,   n_idle;
    logic [7:0]  r_hhb,    n_hhb;

    logic        acc;
    logic [15:0] hword;
    logic [16:0] sum_total;
    logic [15:0] idle_sat;
    logic [15:0] left_m1;

    assign acc       = i_valid && i_ready;
    assign hword     = {r_hhb, i_rx_byte};
    assign sum_total = {1'b0, r_total} + {1'b0, hword};
    assign idle_sat  = (r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle;
    assign left_m1   = r_left - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_mis    = r_mis;
        n_hidx   = r_hidx;
        n_frames = r_frames;
        n_left   = r_left;
        n_total  = r_total;
        n_idle   = r_idle;
        n_hhb    = r_hhb;
        o_push   = 1'b0;
        o_entry  = '0;
        o_entry.event_res  = ctr_pkg::EV_SEND;
        o_entry.error_code = ctr_pkg::ERR_NONE;

        if (acc) begin
            if (i_kind == ctr_pkg::KIND_START) begin
                // re-arm, dropping any transfer in hand
                n_phase  = ctr_pkg::PH_SYN;
                n_mis    = '0;
                n_hidx   = '0;
                n_frames = '0;
                n_left   = '0;
                n_total  = '0;
                n_idle   = '0;
                n_hhb    = '0;
            end else if (r_phase != ctr_pkg::PH_IDLE) begin
                if (i_kind == ctr_pkg::KIND_BYTE) begin
                    n_idle = '0;
                    unique case (r_phase)
                        ctr_pkg::PH_SYN, ctr_pkg::PH_HANGUP: begin
                            if (r_phase == ctr_pkg::PH_SYN && i_rx_byte == i_cfg.syn_code) begin
                                o_push        = 1'b1;
                                o_entry.value = i_cfg.ack_code;
                                n_phase       = ctr_pkg::PH_HEADER;
                                n_hidx        = '0;
                            end else if (r_phase == ctr_pkg::PH_HANGUP &&
                                         i_rx_byte == i_cfg.hangup_code) begin
                                o_push            = 1'b1;
                                o_entry.event_res = ctr_pkg::EV_DONE;
                                o_entry.total_len = r_total;
                                n_phase           = ctr_pkg::PH_IDLE;
                            end else if (r_mis > {1'b0, i_cfg.retry_limit}) begin
                                o_push             = 1'b1;
                                o_entry.event_res  = ctr_pkg::EV_FAIL;
                                o_entry.error_code = ctr_pkg::ERR_SIGNAL;
                                n_phase            = ctr_pkg::PH_IDLE;
                            end else begin
                                n_mis = r_mis + 9'd1;
                            end
                        end
                        ctr_pkg::PH_HEADER: begin
                            if (r_hidx != ctr_pkg::HDR_LAST) begin
                                n_hidx = r_hidx + 2'd1;
                                if (r_hidx[0]) begin
                                    n_frames = hword;
                                end else begin
                                    n_hhb = i_rx_byte;
                                end
                            end else begin
                                n_hidx = '0;
                                if (hword > i_cfg.max_payload) begin
                                    o_push             = 1'b1;
                                    o_entry.event_res  = ctr_pkg::EV_FAIL;
                                    o_entry.error_code = ctr_pkg::ERR_LONG;
                                    n_phase            = ctr_pkg::PH_IDLE;
                                end else if (sum_total > {1'b0, i_cfg.capacity}) begin
                                    o_push             = 1'b1;
                                    o_entry.event_res  = ctr_pkg::EV_FAIL;
                                    o_entry.error_code = ctr_pkg::ERR_OVERFLOW;
                                    n_phase            = ctr_pkg::PH_IDLE;
                                end else if (hword == 16'd0) begin
                                    // empty frame closes at once
                                    o_push        = 1'b1;
                                    o_entry.value = i_cfg.ack_code;
                                    if (r_frames == 16'd0) begin
                                        n_phase = ctr_pkg::PH_HANGUP;
                                        n_mis   = '0;
                                    end else begin
                                        n_phase = ctr_pkg::PH_HEADER;
                                    end
                                end else begin
                                    n_left  = hword;
                                    n_phase = ctr_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        ctr_pkg::PH_PAYLOAD: begin
                            o_push            = 1'b1;
                            o_entry.event_res = ctr_pkg::EV_DATA;
                            o_entry.value     = i_rx_byte;
                            o_entry.offset    = r_total;
                            n_total           = r_total + 16'd1;
                            n_left            = left_m1;
                            if (left_m1 == 16'd0) begin
                                o_entry.ack_after = 1'b1;
                                n_hidx            = '0;
                                if (r_frames == 16'd0) begin
                                    n_phase = ctr_pkg::PH_HANGUP;
                                    n_mis   = '0;
                                end else begin
                                    n_phase = ctr_pkg::PH_HEADER;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (i_kind == ctr_pkg::KIND_TICK) begin
                    n_idle = idle_sat;
                    if (idle_sat >= i_cfg.timeout_ticks) begin
                        o_push             = 1'b1;
                        o_entry.event_res  = ctr_pkg::EV_FAIL;
                        o_entry.error_code = ctr_pkg::ERR_TIMEOUT;
                        n_phase            = ctr_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ctr_pkg::PH_IDLE;
            r_mis    <= '0;
            r_hidx   <= '0;
            r_frames <= '0;
            r_left   <= '0;
            r_total  <= '0;
            r_idle   <= '0;
            r_hhb    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_mis    <= n_mis;
            r_hidx   <= n_hidx;
            r_frames <= n_frames;
            r_left   <= n_left;
            r_total  <= n_total;
            r_idle   <= n_idle;
            r_hhb    <= n_hhb;
        end
    end

endmodule

@@ hdl/ctr_fifo.sv @@
module ctr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ctr_pkg::t_entry i_data,
    input  logic            i_pop,
    output ctr_pkg::t_entry o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ctr_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ hdl/ctr_back.sv @@
module ctr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctr_pkg::t_entry i_head,
    input  logic            i_empty,
    input  logic [7:0]      i_ack_code,
    output logic            o_pop,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    output logic [1:0]      o_m_tuser,
    output logic [47:0]     o_m_tdata,
    output logic            o_m_tlast
);

    logic        r_valid, n_valid;
    logic        r_pend,  n_pend;
    logic        r_last,  n_last;
    logic [1:0]  r_ev,    n_ev;
    logic [7:0]  r_val,   n_val;
    logic [15:0] r_off,   n_off;
    logic [15:0] r_tot,   n_tot;
    logic [2:0]  r_err,   n_err;
    logic        load_ok;

    assign load_ok = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_last  = r_last;
        n_ev    = r_ev;
        n_val   = r_val;
        n_off   = r_off;
        n_tot   = r_tot;
        n_err   = r_err;
        o_pop   = 1'b0;
        if (load_ok) begin
            priority if (r_pend) begin
                // trailing ACK request of a frame
                n_valid = 1'b1;
                n_pend  = 1'b0;
                n_last  = 1'b1;
                n_ev    = ctr_pkg::EV_SEND;
                n_val   = i_ack_code;
                n_off   = '0;
                n_tot   = '0;
                n_err   = ctr_pkg::ERR_NONE;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_pend  = i_head.ack_after;
                n_last  = !i_head.ack_after;
                n_ev    = i_head.event_res;
                n_val   = i_head.value;
                n_off   = i_head.offset;
                n_tot   = i_head.total_len;
                n_err   = i_head.error_code;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_ev   <= n_ev;
        r_val  <= n_val;
        r_off  <= n_off;
        r_tot  <= n_tot;
        r_err  <= n_err;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_ev;
    assign o_m_tdata  = {5'd0, r_err, r_tot, r_off, r_val};
    assign o_m_tlast  = r_last;

`ifndef SYNTHESIS
    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && !r_last)
        else $error("ACK pending without a held data item");
    a_nonlast_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> r_pend)
        else $error("non-final item with no follow-up");
    a_ack_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && i_m_tready) |=> r_valid && r_last && (r_ev == ctr_pkg::EV_SEND))
        else $error("ACK request did not follow the frame's last byte");
`endif

endmodule

@@ tb/sv/chunked_transfer_receiver_tb.sv @@
module chunked_transfer_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  value;
        logic [15:0] offset;
        logic [15:0] total;
        logic [2:0]  err;
        logic        last;
    } t_link_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    // link settings and state as the block should hold them
    logic [7:0]  cfg_syn, cfg_ack, cfg_hangup, cfg_retry;
    logic [15:0] cfg_timeout, cfg_max_pay, cfg_cap;
    logic [2:0]  lk_phase;
    logic [8:0]  miss_cnt;
    logic [1:0]  hdr_idx;
    logic [15:0] frames_left, pay_left, rx_total, tick_cnt;
    logic [7:0]  hdr_hi;

    t_link_result step_results[$];
    t_link_result awaited_events[$];

    int fail_count = 0;
    int items_counted = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    chunked_transfer_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // output stall; a requested hold-off keeps tready low for a long stretch
    always @(posedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_link_result got, want;
        if (rst_n && m_valid && m_ready) begin
            got = t_link_result'({m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                                  m_tdata[42:40], m_tlast});
            if (awaited_events.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= 10)
                    $display("unexpected result: ev %0d val %02h off %0d tot %0d err %0d last %0b",
                             got.ev, got.value, got.offset, got.total, got.err, got.last);
            end else begin
                want = awaited_events.pop_front();
                if (got !== want) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected ev %0d val %02h off %0d tot %0d err %0d last %0b",
                                 want.ev, want.value, want.offset, want.total, want.err,
                                 want.last);
                        $display("          actual   ev %0d val %02h off %0d tot %0d err %0d last %0b",
                                 got.ev, got.value, got.offset, got.total, got.err, got.last);
                    end
                end
            end
        end
    end

    function automatic void reset_link();
        cfg_syn = 8'd22;
        cfg_ack = 8'd6;
        cfg_hangup = 8'd4;
        cfg_retry = 8'd3;
        cfg_timeout = 16'd1000;
        cfg_max_pay = 16'd256;
        cfg_cap = 16'd65535;
        lk_phase = ctr_pkg::PH_IDLE;
        miss_cnt = '0;
        hdr_idx = '0;
        frames_left = '0;
        pay_left = '0;
        rx_total = '0;
        tick_cnt = '0;
        hdr_hi = '0;
    endfunction

    function automatic void note_result(input logic [1:0] ev, input logic [7:0] val,
                                        input logic [15:0] off, input logic [15:0] tot,
                                        input logic [2:0] err);
        step_results.push_back(t_link_result'({ev, val, off, tot, err, 1'b0}));
    endfunction

    function automatic void abort_transfer(input logic [2:0] err);
        note_result(ctr_pkg::EV_FAIL, 8'd0, 16'd0, 16'd0, err);
        lk_phase = ctr_pkg::PH_IDLE;
    endfunction

    // ask for an ACK and move on to the next header or to the hang-up wait
    function automatic void close_frame();
        note_result(ctr_pkg::EV_SEND, cfg_ack, 16'd0, 16'd0, ctr_pkg::ERR_NONE);
        hdr_idx = '0;
        if (frames_left == 0) begin
            lk_phase = ctr_pkg::PH_HANGUP;
            miss_cnt = '0;
        end else begin
            lk_phase = ctr_pkg::PH_HEADER;
        end
    endfunction

    function automatic bit retries_spent();
        if (miss_cnt > {1'b0, cfg_retry})
            return 1'b1;
        miss_cnt = miss_cnt + 1'b1;
        return 1'b0;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        logic [15:0] frame_len;
        tick_cnt = '0;
        case (lk_phase)
            ctr_pkg::PH_SYN: begin
                if (b == cfg_syn) begin
                    note_result(ctr_pkg::EV_SEND, cfg_ack, 16'd0, 16'd0, ctr_pkg::ERR_NONE);
                    lk_phase = ctr_pkg::PH_HEADER;
                    hdr_idx = '0;
                end else if (retries_spent()) begin
                    abort_transfer(ctr_pkg::ERR_SIGNAL);
                end
            end
            ctr_pkg::PH_HEADER: begin
                if (hdr_idx == 2'd0 || hdr_idx == 2'd2) begin
                    hdr_hi = b;
                    hdr_idx = hdr_idx + 1'b1;
                end else if (hdr_idx == 2'd1) begin
                    frames_left = {hdr_hi, b};
                    hdr_idx = 2'd2;
                end else begin
                    frame_len = {hdr_hi, b};
                    hdr_idx = '0;
                    if (frame_len > cfg_max_pay)
                        abort_transfer(ctr_pkg::ERR_LONG);
                    else if ({1'b0, rx_total} + {1'b0, frame_len} > {1'b0, cfg_cap})
                        abort_transfer(ctr_pkg::ERR_OVERFLOW);
                    else if (frame_len == 0)
                        close_frame();
                    else begin
                        pay_left = frame_len;
                        lk_phase = ctr_pkg::PH_PAYLOAD;
                    end
                end
            end
            ctr_pkg::PH_PAYLOAD: begin
                note_result(ctr_pkg::EV_DATA, b, rx_total, 16'd0, ctr_pkg::ERR_NONE);
                rx_total = rx_total + 1'b1;
                pay_left = pay_left - 1'b1;
                if (pay_left == 0)
                    close_frame();
            end
            ctr_pkg::PH_HANGUP: begin
                if (b == cfg_hangup) begin
                    note_result(ctr_pkg::EV_DONE, 8'd0, 16'd0, rx_total, ctr_pkg::ERR_NONE);
                    lk_phase = ctr_pkg::PH_IDLE;
                end else if (retries_spent()) begin
                    abort_transfer(ctr_pkg::ERR_SIGNAL);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_link(input logic [1:0] kind, input logic [7:0] b);
        t_link_result r;
        int i;
        step_results.delete();
        if (kind == ctr_pkg::KIND_START) begin
            lk_phase = ctr_pkg::PH_SYN;
            miss_cnt = '0;
            hdr_idx = '0;
            frames_left = '0;
            pay_left = '0;
            rx_total = '0;
            tick_cnt = '0;
            hdr_hi = '0;
        end else if (lk_phase != ctr_pkg::PH_IDLE) begin
            if (kind == ctr_pkg::KIND_BYTE) begin
                take_byte(b);
            end else if (kind == ctr_pkg::KIND_TICK) begin
                if (tick_cnt != 16'hFFFF)
                    tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= cfg_timeout)
                    abort_transfer(ctr_pkg::ERR_TIMEOUT);
            end
        end
        for (i = 0; i < step_results.size(); i++) begin
            r = step_results[i];
            r.last = (i == step_results.size() - 1);
            awaited_events.push_back(r);
        end
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_tdata <= b;
        s_tuser <= kind;
        do @(posedge clk); while (!s_ready);
        if (kind == ctr_pkg::KIND_START ||
            (kind != KIND_SPARE && lk_phase != ctr_pkg::PH_IDLE))
            items_counted = items_counted + 1;
        predict_link(kind, b);
    endtask

    // drop valid and wait for every awaited result, then idle for the extra cycles asked for
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        do @(posedge clk); while (awaited_events.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            ctr_pkg::REG_SYN_CODE:      cfg_syn = val[7:0];
            ctr_pkg::REG_ACK_CODE:      cfg_ack = val[7:0];
            ctr_pkg::REG_HANGUP_CODE:   cfg_hangup = val[7:0];
            ctr_pkg::REG_RETRY_LIMIT:   cfg_retry = val[7:0];
            ctr_pkg::REG_TIMEOUT_TICKS: cfg_timeout = val;
            ctr_pkg::REG_MAX_PAYLOAD:   cfg_max_pay = val;
            ctr_pkg::REG_CAPACITY:      cfg_cap = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_header(input logic [15:0] remaining, input logic [15:0] len);
        send_item(ctr_pkg::KIND_BYTE, remaining[15:8]);
        send_item(ctr_pkg::KIND_BYTE, remaining[7:0]);
        send_item(ctr_pkg::KIND_BYTE, len[15:8]);
        send_item(ctr_pkg::KIND_BYTE, len[7:0]);
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] code);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == code)
            b = b + 1'b1;
        return b;
    endfunction

    function automatic int wrong_count();
        int top;
        if ($urandom_range(0, 9) == 0)
            return (cfg_retry < 8) ? cfg_retry + 2 : 2;
        top = (cfg_retry < 1) ? 1 : 2;
        return $urandom_range(0, top);
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4 && cfg_max_pay != 16'hFFFF)
            return cfg_max_pay + 1'b1;
        if (r < 7)
            return (cfg_max_pay < 64) ? cfg_max_pay : 16'($urandom_range(11, 64));
        return (cfg_max_pay < 10) ? 16'($urandom_range(0, cfg_max_pay))
                                  : 16'($urandom_range(0, 10));
    endfunction

    // byte with occasional ticks and spare kinds mixed in ahead of it
    task automatic link_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 8)
            send_item(ctr_pkg::KIND_TICK, 8'($urandom));
        if ($urandom_range(0, 99) == 0)
            send_item(KIND_SPARE, 8'($urandom));
        send_item(ctr_pkg::KIND_BYTE, b);
    endtask

    task automatic run_transfer();
        int i, f, n;
        logic [15:0] remaining, frame_len;
        logic [31:0] hdr;
        send_item(ctr_pkg::KIND_START, 8'($urandom));
        n = wrong_count();
        for (i = 0; i < n; i++) begin
            link_byte(byte_other_than(cfg_syn));
            if (lk_phase == ctr_pkg::PH_IDLE) return;
        end
        link_byte(cfg_syn);
        n = $urandom_range(1, 4);
        for (f = 0; f < n; f++) begin
            remaining = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'(n - 1 - f);
            frame_len = pick_len();
            hdr = {remaining, frame_len};
            for (i = 3; i >= 0; i--) begin
                if (lk_phase == ctr_pkg::PH_IDLE) return;
                link_byte(hdr[i*8 +: 8]);
            end
            if (lk_phase != ctr_pkg::PH_PAYLOAD)
                continue;
            for (i = 0; i < frame_len; i++) begin
                if (lk_phase == ctr_pkg::PH_IDLE) return;
                if ($urandom_range(0, 199) == 0) begin
                    send_item(ctr_pkg::KIND_START, 8'($urandom));
                    return;
                end
                link_byte(8'($urandom));
            end
        end
        n = wrong_count();
        for (i = 0; i < n; i++) begin
            if (lk_phase == ctr_pkg::PH_IDLE) return;
            link_byte(byte_other_than(cfg_hangup));
        end
        if (lk_phase != ctr_pkg::PH_IDLE)
            link_byte(cfg_hangup);
    endtask

    task automatic randomize_config();
        write_reg(ctr_pkg::REG_SYN_CODE, 16'($urandom_range(0, 255)));
        write_reg(ctr_pkg::REG_ACK_CODE, 16'($urandom_range(0, 255)));
        write_reg(ctr_pkg::REG_HANGUP_CODE, 16'($urandom_range(0, 255)));
        write_reg(ctr_pkg::REG_RETRY_LIMIT, 16'($urandom_range(0, 4)));
        case ($urandom_range(0, 3))
            0: write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd2);
            1: write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd5);
            2: write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd40);
            default: write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'd1);
            1: write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'd8);
            2: write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'd256);
            default: write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'hFFFF);
        endcase
        case ($urandom_range(0, 2))
            0: write_reg(ctr_pkg::REG_CAPACITY, 16'd12);
            1: write_reg(ctr_pkg::REG_CAPACITY, 16'd60);
            default: write_reg(ctr_pkg::REG_CAPACITY, 16'hFFFF);
        endcase
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        stall_pct <= 0;
        send_item(ctr_pkg::KIND_BYTE, 8'h55);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        send_item(KIND_SPARE, 8'hAA);
        send_item(ctr_pkg::KIND_START, 8'hFF);
        send_item(ctr_pkg::KIND_BYTE, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd1, 16'd0);
        send_header(16'd0, 16'd2);
        send_item(ctr_pkg::KIND_BYTE, 8'hFF);
        send_item(ctr_pkg::KIND_BYTE, 8'h00);
        send_item(ctr_pkg::KIND_TICK, 8'hFF);
        send_item(ctr_pkg::KIND_BYTE, cfg_hangup);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'hFF00, 16'd257);
    endtask

    task automatic test_signal_codes();
        int i;
        settle(DRAIN_CYCLES);
        sender_idle_pct = 21;
        stall_pct <= 21;
        write_reg(ctr_pkg::REG_SYN_CODE, 16'd0);
        write_reg(ctr_pkg::REG_ACK_CODE, 16'd255);
        write_reg(ctr_pkg::REG_HANGUP_CODE, 16'd255);
        write_reg(ctr_pkg::REG_RETRY_LIMIT, 16'd0);
        // one wrong byte is tolerated, the second fails
        send_item(ctr_pkg::KIND_START, 8'h12);
        send_item(ctr_pkg::KIND_BYTE, 8'h80);
        send_item(ctr_pkg::KIND_BYTE, 8'h01);
        send_item(ctr_pkg::KIND_START, 8'h34);
        send_item(ctr_pkg::KIND_BYTE, 8'hFF);
        send_item(ctr_pkg::KIND_BYTE, 8'h00);
        send_header(16'd0, 16'd1);
        send_item(ctr_pkg::KIND_BYTE, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, 8'h7F);
        send_item(ctr_pkg::KIND_BYTE, 8'hFF);
        settle(DRAIN_CYCLES);
        write_reg(ctr_pkg::REG_RETRY_LIMIT, 16'd255);
        send_item(ctr_pkg::KIND_START, 8'h00);
        for (i = 0; i < 257; i++)
            send_item(ctr_pkg::KIND_BYTE, byte_other_than(cfg_syn));
    endtask

    task automatic test_timeout();
        int i;
        settle(DRAIN_CYCLES);
        sender_idle_pct = 21;
        stall_pct <= 21;
        write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd0);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        settle(DRAIN_CYCLES);
        write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd1);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        settle(DRAIN_CYCLES);
        write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'd3);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        send_item(ctr_pkg::KIND_TICK, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, byte_other_than(cfg_syn));
        for (i = 0; i < 3; i++)
            send_item(ctr_pkg::KIND_TICK, 8'h00);
        settle(DRAIN_CYCLES);
        write_reg(ctr_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        for (i = 0; i < 5; i++)
            send_item(ctr_pkg::KIND_TICK, 8'h00);
        send_header(16'd0, 16'd0);
    endtask

    task automatic test_frame_limits();
        settle(DRAIN_CYCLES);
        sender_idle_pct = 21;
        stall_pct <= 21;
        write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'd1);
        write_reg(ctr_pkg::REG_CAPACITY, 16'd1);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd1, 16'd1);
        send_item(ctr_pkg::KIND_BYTE, 8'hA5);
        send_header(16'd0, 16'd1);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd0, 16'd2);
        settle(DRAIN_CYCLES);
        write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'hFFFF);
        write_reg(ctr_pkg::REG_CAPACITY, 16'hFFFF);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd1, 16'd2);
        send_item(ctr_pkg::KIND_BYTE, 8'h5A);
        send_item(ctr_pkg::KIND_BYTE, 8'hC3);
        send_header(16'd0, 16'hFFFF);
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd0, 16'd0);
        send_item(ctr_pkg::KIND_BYTE, byte_other_than(cfg_hangup));
        send_item(ctr_pkg::KIND_BYTE, cfg_hangup);
    endtask

    // hold the output while the input keeps coming, then pause until drained
    task automatic test_backpressure();
        int i;
        settle(DRAIN_CYCLES);
        sender_idle_pct = 0;
        stall_pct <= 0;
        write_reg(ctr_pkg::REG_MAX_PAYLOAD, 16'd256);
        write_reg(ctr_pkg::REG_CAPACITY, 16'hFFFF);
        hold_reqs <= hold_reqs + 1;
        send_item(ctr_pkg::KIND_START, 8'h00);
        send_item(ctr_pkg::KIND_BYTE, cfg_syn);
        send_header(16'd0, 16'd40);
        for (i = 0; i < 20; i++)
            send_item(ctr_pkg::KIND_BYTE, 8'($urandom));
        settle(0);
        for (i = 0; i < 20; i++)
            send_item(ctr_pkg::KIND_BYTE, 8'($urandom));
        send_item(ctr_pkg::KIND_BYTE, cfg_hangup);
    endtask

    task automatic test_random(input int send_pct, input int stall_v, input int n);
        int target;
        settle(DRAIN_CYCLES);
        randomize_config();
        sender_idle_pct = send_pct;
        stall_pct <= stall_v;
        target = items_counted + n;
        while (items_counted < target)
            run_transfer();
    endtask

    initial begin
        reset_link();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_signal_codes();
        test_timeout();
        test_frame_limits();
        test_backpressure();
        test_random(0, 0, 275);
        test_random(78, 0, 275);
        test_random(0, 78, 275);
        test_random(21, 21, 275);
        settle(2 * DRAIN_CYCLES);
        if (fail_count == 0 && awaited_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
